/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* src/sbsh_pkg.sv */
// ----------------------------------------------------------------------------
// sbsh_pkg
// Types, constants and round functions of the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbsh_pkg;

   localparam int WORD_W = 32;

   typedef logic [WORD_W-1:0] word_type;

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type HASH_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // Controls of the message schedule window
   typedef struct packed {
      logic       load;       // shift one message byte in
      logic [7:0] load_byte;
      logic       step;       // advance one round
   } sched_ctrl_type;

   // Controls of the round unit
   typedef struct packed {
      logic       init;       // copy hash words into working variables
      logic       step;       // run one round
      logic       fold;       // add working variables into hash words
      logic       restart;    // return hash words to initial values
      logic [5:0] rnd;
   } round_ctrl_type;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

/* src/sbsh_sched.sv */
// ----------------------------------------------------------------------------
// sbsh_sched
// Sixteen-word message window: takes the block byte by byte, then produces
// one schedule word per round, oldest word at the head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbsh_sched (
   input  logic                    clock,
   input  sbsh_pkg::sched_ctrl_type ctrl,
   output sbsh_pkg::word_type      w_head
);

   sbsh_pkg::word_type win_ff [16];
   sbsh_pkg::word_type win_in [16];
   sbsh_pkg::word_type next_w;

   // Word t+16 from words t, t+1, t+9 and t+14
   assign next_w = sbsh_pkg::small_sigma1(win_ff[14]) + win_ff[9]
                 + sbsh_pkg::small_sigma0(win_ff[1]) + win_ff[0];

   assign w_head = win_ff[0];

   always_comb begin
      win_in = win_ff;
      if (ctrl.load) begin
         // byte-wide shift through the whole window, first byte ends at the top
         for (int i = 0; i < 15; i++) begin
            win_in[i] = {win_ff[i][23:0], win_ff[i+1][31:24]};
         end
         win_in[15] = {win_ff[15][23:0], ctrl.load_byte};
      end else if (ctrl.step) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[15] = next_w;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

/* src/sbsh_round.sv */
// ----------------------------------------------------------------------------
// sbsh_round
// SHA-256 round unit: eight working variables, one round per cycle while step is
// set, and the hash words that the working variables fold into after each block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbsh_round (
   input  logic                    clock,
   input  logic                    reset,
   input  sbsh_pkg::round_ctrl_type ctrl,
   input  sbsh_pkg::word_type      w,
   output logic [7:0][31:0]        hash_words
);

   sbsh_pkg::word_type v_ff [8];
   sbsh_pkg::word_type v_in [8];
   sbsh_pkg::word_type hash_ff [8];
   sbsh_pkg::word_type hash_in [8];
   sbsh_pkg::word_type ch;
   sbsh_pkg::word_type maj;
   sbsh_pkg::word_type t1;
   sbsh_pkg::word_type t2;

   assign ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1  = v_ff[7] + sbsh_pkg::big_sigma1(v_ff[4]) + ch
              + sbsh_pkg::ROUND_K[ctrl.rnd] + w;
   assign t2  = sbsh_pkg::big_sigma0(v_ff[0]) + maj;

   always_comb begin
      v_in    = v_ff;
      hash_in = hash_ff;
      if (ctrl.init) begin
         v_in = hash_ff;
      end else if (ctrl.step) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
      if (ctrl.restart) begin
         hash_in = sbsh_pkg::HASH_IV;
      end else if (ctrl.fold) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= sbsh_pkg::HASH_IV;
      end else begin
         hash_ff <= hash_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         hash_words[i] = hash_ff[i];
      end
   end

endmodule

/* src/sha256_byte_stream_hasher.sv */
// Absorb: one byte per cycle while idle; the input is busy after the 64th byte
// of a block (64 rounds of the shared round unit, then a fold of the hash).
// Finalize: one padding byte per cycle up to the block end (a second block
// when more than 55 bytes are buffered), rounds and fold per padded block, then
// eight digest transfers.
// Reset (synchronous) loads the initial hash and clears counts.
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream with padding and digest output on finalize.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha256_byte_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] message_byte
   input  logic        req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, zero above
   output logic        rsp_tlast    // last_word
);

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINAL  = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_FOLD  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] len_ff, len_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [2:0]  idx_ff, idx_in;
   logic        fin_ff, fin_in;
   logic        first_ff, first_in;
   logic        extra_ff, extra_in;
   logic        lastblk_ff, lastblk_in;

   sbsh_pkg::sched_ctrl_type sctl;
   sbsh_pkg::round_ctrl_type rctl;
   sbsh_pkg::word_type       w_head;
   logic [7:0][31:0]         hash_words;

   logic        req_fire;
   logic        rsp_fire;
   logic [63:0] len_bits;
   logic [7:0]  pad_byte;
   logic        extra_now;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tlast  = (idx_ff == 3'd7);
   assign rsp_tdata  = {5'd0, idx_ff, hash_words[idx_ff]};

   assign len_bits  = {len_ff, 3'b000};
   // a 0x80 marker in the last eight bytes pushes the length to a fresh block
   assign extra_now = first_ff ? (fill_ff[5:3] == 3'b111) : extra_ff;

   always_comb begin
      if (first_ff) begin
         pad_byte = 8'h80;
      end else if (!extra_ff && (fill_ff[5:3] == 3'b111)) begin
         pad_byte = len_bits[{~fill_ff[2:0], 3'b000} +: 8];
      end else begin
         pad_byte = 8'h00;
      end
   end

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      len_in     = len_ff;
      rnd_in     = rnd_ff;
      idx_in     = idx_ff;
      fin_in     = fin_ff;
      first_in   = first_ff;
      extra_in   = extra_ff;
      lastblk_in = lastblk_ff;
      sctl       = '0;
      rctl       = '0;
      rctl.rnd   = rnd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == OP_FINAL) begin
                  fin_in   = 1'b1;
                  first_in = 1'b1;
                  state_in = ST_PAD;
               end else begin
                  sctl.load      = 1'b1;
                  sctl.load_byte = req_tdata;
                  len_in         = len_ff + 61'd1;
                  fill_in        = fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     rctl.init = 1'b1;
                     rnd_in    = 6'd0;
                     state_in  = ST_ROUND;
                  end
               end
            end
         end
         ST_PAD: begin
            sctl.load      = 1'b1;
            sctl.load_byte = pad_byte;
            fill_in        = fill_ff + 6'd1;
            first_in       = 1'b0;
            extra_in       = extra_now;
            if (fill_ff == 6'd63) begin
               rctl.init  = 1'b1;
               rnd_in     = 6'd0;
               lastblk_in = !extra_now;
               extra_in   = 1'b0;
               state_in   = ST_ROUND;
            end
         end
         ST_ROUND: begin
            rctl.step = 1'b1;
            sctl.step = 1'b1;
            rnd_in    = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            rctl.fold = 1'b1;
            if (lastblk_ff) begin
               idx_in   = 3'd0;
               state_in = ST_OUT;
            end else if (fin_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  // drop back to the initial hash for the next message
                  rctl.restart = 1'b1;
                  fin_in       = 1'b0;
                  lastblk_in   = 1'b0;
                  len_in       = '0;
                  fill_in      = '0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= '0;
         len_ff     <= '0;
         rnd_ff     <= '0;
         idx_ff     <= '0;
         fin_ff     <= 1'b0;
         first_ff   <= 1'b0;
         extra_ff   <= 1'b0;
         lastblk_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         len_ff     <= len_in;
         rnd_ff     <= rnd_in;
         idx_ff     <= idx_in;
         fin_ff     <= fin_in;
         first_ff   <= first_in;
         extra_ff   <= extra_in;
         lastblk_ff <= lastblk_in;
      end
   end

   sbsh_sched u_sched (
      .clock  (clock),
      .ctrl   (sctl),
      .w_head (w_head)
   );

   sbsh_round u_round (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (rctl),
      .w          (w_head),
      .hash_words (hash_words)
   );

   `ASSERT_NEVER(a_ready_while_out, clock, reset, req_tready && rsp_tvalid, "input ready during digest output")
   `ASSERT_CLK(a_idle_after_last, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready, "not idle after last digest word")
   `ASSERT_CLK(a_full_block_runs, clock, reset, req_tvalid && req_tready && (req_tuser == OP_ABSORB) && (fill_ff == 6'd63) |=> (state_ff == ST_ROUND) && (rnd_ff == 6'd0), "full block did not start rounds")
   `ASSERT_CLK(a_rounds_fold, clock, reset, (state_ff == ST_ROUND) && (rnd_ff == 6'd63) |=> (state_ff == ST_FOLD), "round 63 not followed by fold")

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sha256_byte_stream_hasher: a software SHA-256 model
// predicts the digest of each finalized message; byte streams (directed,
// block-boundary lengths and random) are driven in bursts against a
// stalling receiver, and every digest word is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 300;
   localparam int TARGET_ITEMS = 430;

   typedef enum logic {OP_ABSORB = 1'b0, OP_FINALIZE = 1'b1} opcode_type;

   typedef struct packed {
      opcode_type op;
      logic [7:0] data;
   } hash_req_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   localparam logic [31:0] K_TABLE [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] IV_TABLE [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] message_byte
   logic        req_tuser = 1'b0;     // [0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;            // [31:0] digest_word, [34:32] word_index, zero above
   logic        rsp_tlast;            // last_word

   hash_req_type    pending_reqs [$];
   digest_word_type want_words [$];
   int              mismatches = 0;

   // software hash state
   logic [31:0] chain [8];
   logic [7:0]  block_buf [64];
   int unsigned fill;
   logic [60:0] byte_count;

   sha256_byte_stream_hasher u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void restart_hash();
      for (int i = 0; i < 8; i++) chain[i] = IV_TABLE[i];
      fill = 0;
      byte_count = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int t = 0; t < 16; t++)
         w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
      for (int t = 16; t < 64; t++) begin
         s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int t = 0; t < 64; t++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
              + K_TABLE[t] + w[t];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
              + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
   endfunction

   // Advance the software hash by one accepted request; finalize queues 8 words.
   function automatic void hash_request(input hash_req_type req);
      logic [63:0]     bit_len;
      int unsigned     pos;
      digest_word_type dw;
      if (req.op == OP_ABSORB) begin
         block_buf[fill] = req.data;
         byte_count = byte_count + 61'd1;
         fill++;
         if (fill == 64) begin
            compress_block();
            fill = 0;
         end
      end else begin
         bit_len = {byte_count, 3'b000};
         pos = fill;
         block_buf[pos] = 8'h80;
         pos++;
         // no room for the length: pad out and spend an extra block
         if (pos > 56) begin
            while (pos < 64) begin
               block_buf[pos] = 8'h00;
               pos++;
            end
            compress_block();
            pos = 0;
         end
         while (pos < 56) begin
            block_buf[pos] = 8'h00;
            pos++;
         end
         for (int i = 0; i < 8; i++) block_buf[56+i] = bit_len[63-8*i -: 8];
         compress_block();
         for (int i = 0; i < 8; i++) begin
            dw.word = chain[i];
            dw.index = i[2:0];
            dw.last = (i == 7);
            want_words.push_back(dw);
         end
         restart_hash();
      end
   endfunction

   function automatic void queue_req(input opcode_type op, input logic [7:0] data);
      hash_req_type r;
      r.op = op;
      r.data = data;
      pending_reqs.push_back(r);
   endfunction

   // One message of len bytes; style 0 random, 1 all zeros, 2 all ones.
   function automatic void queue_message(input int len, input int style);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         b = (style == 1) ? 8'h00 : (style == 2) ? 8'hff : 8'($urandom);
         queue_req(OP_ABSORB, b);
      end
      queue_req(OP_FINALIZE, 8'($urandom));
   endfunction

   // Request driver: bursts of random length separated by random gaps.
   int burst_left = 8;
   int gap_left = 0;

   always @(posedge clock) begin : driver
      hash_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) hash_request(hash_req_type'({req_tuser, req_tdata}));
         // hold the item until it transfers
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               nxt = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= nxt.op;
               req_tdata <= nxt.data;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: rotating stall pattern plus long hold-offs that back up the input.
   int rx_cycle = 0;
   int hold_left = 0;

   always @(posedge clock) begin : receiver
      int mode;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle == 1000 || rx_cycle == 4000) hold_left = 600;
         mode = (rx_cycle / 97) % 4;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom);
               2: rsp_tready <= (rx_cycle % 5 == 0);
               default: rsp_tready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : monitor
      digest_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (want_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected digest transfer: word %h index %0d last %b",
                        rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast);
         end else begin
            want = want_words.pop_front();
            if (rsp_tdata[31:0] !== want.word || rsp_tdata[34:32] !== want.index ||
                rsp_tlast !== want.last || rsp_tdata[39:35] !== 5'd0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"digest mismatch: expected word %h index %0d last %b, ",
                            "got %h %0d %b pad %b"},
                           want.word, want.index, want.last, rsp_tdata[31:0],
                           rsp_tdata[34:32], rsp_tlast, rsp_tdata[39:35]);
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL sha256_byte_stream_hasher");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int r;
      int len;
      int boundary [8];
      boundary = '{54, 55, 56, 57, 62, 63, 64, 65};
      restart_hash();

      // empty message
      queue_req(OP_FINALIZE, 8'hff);
      // "abc"
      queue_req(OP_ABSORB, 8'h61);
      queue_req(OP_ABSORB, 8'h62);
      queue_req(OP_ABSORB, 8'h63);
      queue_req(OP_FINALIZE, 8'h00);
      // byte extremes
      queue_req(OP_ABSORB, 8'h00);
      queue_req(OP_ABSORB, 8'hff);
      queue_req(OP_ABSORB, 8'h80);
      queue_req(OP_ABSORB, 8'h01);
      queue_req(OP_FINALIZE, 8'h5a);
      // back-to-back finalize, then a single byte
      queue_req(OP_FINALIZE, 8'h00);
      queue_req(OP_ABSORB, 8'h55);
      queue_req(OP_FINALIZE, 8'haa);

      // Random messages, weighted toward the padding boundaries.
      while (pending_reqs.size() < TARGET_ITEMS) begin
         r = $urandom_range(0, 9);
         if (r <= 5) len = $urandom_range(0, 24);
         else if (r <= 7) len = boundary[$urandom_range(0, 7)];
         else if (r == 8) len = $urandom_range(100, 140);
         else len = $urandom_range(0, 3);
         // trim the last message so the total lands on the target
         if (len > TARGET_ITEMS - 1 - pending_reqs.size())
            len = TARGET_ITEMS - 1 - pending_reqs.size();
         queue_message(len, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || req_tvalid) @(posedge clock);
      while (want_words.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (want_words.size() > 0) mismatches++;
      if (mismatches == 0) begin
         $display("PASS sha256_byte_stream_hasher");
      end else begin
         $display("FAIL sha256_byte_stream_hasher");
      end
      $finish;
   end

endmodule
